// ===== hw/rtl/multi_channel_ring_fifo_unit_macros.svh =====
// assertion macros for the multi-channel ring fifo unit
// no dependencies; included by the modules that carry assertions
`ifndef MULTI_CHANNEL_RING_FIFO_UNIT_MACROS_SVH
`define MULTI_CHANNEL_RING_FIFO_UNIT_MACROS_SVH

// condition holds at every edge out of reset
`define MCRF_ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("mcrf assertion failed");

// consequent holds in the same cycle as the antecedent
`define MCRF_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mcrf assertion failed");

// consequent holds in the cycle after the antecedent
`define MCRF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mcrf assertion failed");

`endif

// ===== hw/rtl/mcrf_pkg.sv =====
// shared types, codes and constants of the multi-channel ring fifo unit
// no dependencies
package mcrf_pkg;

  localparam int DEFAULT_DEPTH = 1024;
  localparam int CHANNELS      = 2;
  localparam int CH_W          = $clog2(CHANNELS);
  localparam int MAX_RUN       = 64;
  localparam int ELEM_W        = 8;

  localparam int CMD_W   = 3;
  localparam int CHSEL_W = 2;
  localparam int LEN_W   = 7;
  localparam int BYTE_W  = 8;
  localparam int STS_W   = 2;
  localparam int FILL_W  = 11;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = CHANNELS;

  localparam logic [CFG_IDX_W-1:0] REG_PUSH_PARTIAL = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_POP_PARTIAL  = 1'b1;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH  = 3'd0,
    CMD_PEEK  = 3'd1,
    CMD_POP   = 3'd2,
    CMD_COUNT = 3'd3,
    CMD_CLEAR = 3'd4
  } cmd_t;

  typedef enum logic [STS_W-1:0] {
    STS_OK    = 2'd0,
    STS_FULL  = 2'd1,
    STS_EMPTY = 2'd2,
    STS_PARAM = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_RD,
    S_LOAD
  } fsm_t;

  // controller to datapath
  typedef struct packed {
    logic load_item;
    logic exec;
    logic rd_issue;
    logic rd_load;
  } ctl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_free;
    logic start_read;
    logic read_last;
  } ctl_sts_t;

endpackage

// ===== hw/rtl/multi_channel_ring_fifo_unit.sv =====
// multi-channel ring fifo unit: two byte fifos with push, peek, pop, count and clear
// one input word per command or push byte, one or more result words per input word
// holds flip-flop channel indices and counts and the byte store; depends on
// mcrf_pkg, mcrf_ctrl, mcrf_datapath and mcrf_ram
//
// in_* carries commands: tuser = command, channel; tdata = length, push byte;
// tlast marks the final byte of a push run. a push run is granted at its first
// byte (whole run, free space when partial, or nothing) and each byte gives one
// result word. peek and pop give one result per byte read, tlast on the last.
// out_* carries results: tuser = status; tdata = data byte, fill count.
// cfg_we writes a partial-mode mask (index 0 push, index 1 pop).
// an item with a single result is latched on acceptance and then loaded into
// the output register in the exec state; the next item is taken only once the
// sequencer is back in idle. a peek or pop passes the exec state and then, for
// each byte, reads the registered read port of the store in the rd state and
// loads the byte in the load state. a new item is taken the cycle after the
// previous item's last result is loaded. reset clears indices, counts and
// the push run and sets both masks; the store needs no clearing pass. when
// out_tready is low the output register holds its word, the sequencer waits
// and one more word is taken in and held.
module multi_channel_ring_fifo_unit #(
  parameter int DEPTH = mcrf_pkg::DEFAULT_DEPTH
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [15:0]                     in_tdata,   // length, push_byte
  input  logic [4:0]                      in_tuser,   // command, channel
  input  logic                            in_tlast,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [23:0]                     out_tdata,  // data_out, fill_count
  output logic [1:0]                      out_tuser,  // status
  output logic                            out_tlast,
  input  logic                            cfg_we,
  input  logic [mcrf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mcrf_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import mcrf_pkg::*;

  ctl_cmd_t          ctl_cmd;
  ctl_sts_t          ctl_sts;
  logic [STS_W-1:0]  res_status;
  logic [BYTE_W-1:0] res_data;
  logic [FILL_W-1:0] res_fill;

  mcrf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts_i     (ctl_sts),
    .cmd_o     (ctl_cmd)
  );

  mcrf_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd_i        (ctl_cmd),
    .sts_o        (ctl_sts),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .in_command   (in_tuser[2:0]),
    .in_channel   (in_tuser[4:3]),
    .in_length    (in_tdata[6:0]),
    .in_push_byte (in_tdata[14:7]),
    .in_run_end   (in_tlast),
    .out_tready   (out_tready),
    .out_valid    (out_tvalid),
    .out_status   (res_status),
    .out_data     (res_data),
    .out_fill     (res_fill),
    .out_last     (out_tlast)
  );

  assign out_tuser = res_status;
  assign out_tdata = {5'b0, res_fill, res_data};

endmodule

// ===== hw/rtl/mcrf_ram.sv =====
// generic single-write, single-read ram with registered read data
// no dependencies
module mcrf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hw/rtl/mcrf_ctrl.sv =====
// sequencing state machine of the multi-channel ring fifo unit
// depends on mcrf_pkg
module mcrf_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  mcrf_pkg::ctl_sts_t sts_i,
  output mcrf_pkg::ctl_cmd_t cmd_o
);
  import mcrf_pkg::*;

  fsm_t state_r;
  fsm_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd_o     = '0;
    in_tready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd_o.load_item = 1'b1;
          state_nxt       = S_EXEC;
        end
      end
      S_EXEC: begin
        if (sts_i.out_free) begin
          cmd_o.exec = 1'b1;
          state_nxt  = sts_i.start_read ? S_RD : S_IDLE;
        end
      end
      S_RD: begin
        if (sts_i.out_free) begin
          cmd_o.rd_issue = 1'b1;
          state_nxt      = S_LOAD;
        end
      end
      S_LOAD: begin
        cmd_o.rd_load = 1'b1;
        state_nxt     = sts_i.read_last ? S_IDLE : S_RD;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// ===== hw/rtl/mcrf_datapath.sv =====
// ring indices, fill counts, push run state, byte store and output register
// depends on mcrf_pkg, mcrf_ram and the assertion macros header
`include "multi_channel_ring_fifo_unit_macros.svh"

module mcrf_datapath #(
  parameter int DEPTH = mcrf_pkg::DEFAULT_DEPTH
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  mcrf_pkg::ctl_cmd_t              cmd_i,
  output mcrf_pkg::ctl_sts_t              sts_o,
  input  logic                            cfg_we,
  input  logic [mcrf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mcrf_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic [mcrf_pkg::CMD_W-1:0]      in_command,
  input  logic [mcrf_pkg::CHSEL_W-1:0]    in_channel,
  input  logic [mcrf_pkg::LEN_W-1:0]      in_length,
  input  logic [mcrf_pkg::BYTE_W-1:0]     in_push_byte,
  input  logic                            in_run_end,
  input  logic                            out_tready,
  output logic                            out_valid,
  output logic [mcrf_pkg::STS_W-1:0]      out_status,
  output logic [mcrf_pkg::BYTE_W-1:0]     out_data,
  output logic [mcrf_pkg::FILL_W-1:0]     out_fill,
  output logic                            out_last
);
  import mcrf_pkg::*;

  localparam int IDX_W  = $clog2(2 * DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int ADDR_W = $clog2(CHANNELS * DEPTH);

  function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] idx);
    logic [IDX_W-1:0] res;
    res = (32'(idx) + 1 >= 2 * DEPTH) ? '0 : idx + 1'b1;
    return res;
  endfunction

  function automatic logic [ADDR_W-1:0] slot_addr(input logic [CH_W-1:0] c,
                                                  input logic [IDX_W-1:0] idx);
    logic [IDX_W-1:0] p;
    p = (32'(idx) >= DEPTH) ? idx - IDX_W'(DEPTH) : idx;
    return ADDR_W'(c) * ADDR_W'(DEPTH) + ADDR_W'(p);
  endfunction

  // latched item
  cmd_t               cmd_r;
  logic [CHSEL_W-1:0] ch_r;
  logic [LEN_W-1:0]   len_r;
  logic [BYTE_W-1:0]  byte_r;
  logic               end_r;

  // control state
  logic [IDX_W-1:0]      wr_idx_r [CHANNELS];
  logic [IDX_W-1:0]      wr_idx_nxt [CHANNELS];
  logic [IDX_W-1:0]      rd_idx_r [CHANNELS];
  logic [IDX_W-1:0]      rd_idx_nxt [CHANNELS];
  logic [CNT_W-1:0]      cnt_r [CHANNELS];
  logic [CNT_W-1:0]      cnt_nxt [CHANNELS];
  logic [LEN_W-1:0]      push_rem_r, push_rem_nxt;
  logic                  push_short_r, push_short_nxt;
  logic                  push_open_r, push_open_nxt;
  logic [CHSEL_W-1:0]    run_ch_r, run_ch_nxt;
  logic [CFG_DATA_W-1:0] push_mask_r, push_mask_nxt;
  logic [CFG_DATA_W-1:0] pop_mask_r, pop_mask_nxt;
  logic [LEN_W-1:0]      rd_left_r, rd_left_nxt;
  logic [IDX_W-1:0]      rd_ptr_r, rd_ptr_nxt;
  logic                  out_valid_r, out_valid_nxt;

  // output word
  logic [STS_W-1:0]  out_status_r, out_status_nxt;
  logic [BYTE_W-1:0] out_data_r, out_data_nxt;
  logic [FILL_W-1:0] out_fill_r, out_fill_nxt;
  logic              out_last_r, out_last_nxt;
  logic              out_load;

  // store port
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic              ram_re;
  logic [ADDR_W-1:0] ram_raddr;
  logic [ELEM_W-1:0] ram_rdata;

  logic [CHSEL_W-1:0] sel_ch;
  logic [CH_W-1:0]    sel;
  logic [CNT_W-1:0]   cnt_sel;
  logic [CNT_W-1:0]   free_sel;
  logic               bad;
  logic               ch_bad;
  logic [LEN_W-1:0]   push_grant;
  logic [LEN_W-1:0]   read_grant;
  logic [LEN_W-1:0]   rem_eff;
  logic               short_eff;
  logic [CNT_W-1:0]   cnt_after;

  assign sel_ch   = (cmd_r == CMD_PUSH && push_open_r) ? run_ch_r : ch_r;
  assign sel      = sel_ch[CH_W-1:0];
  assign cnt_sel  = cnt_r[sel];
  assign free_sel = CNT_W'(DEPTH) - cnt_sel;
  assign ch_bad   = 32'(ch_r) >= CHANNELS;
  assign bad      = ch_bad || len_r == '0 || 32'(len_r) > MAX_RUN;

  always_comb begin
    if (32'(free_sel) >= 32'(len_r)) begin
      push_grant = len_r;
    end else if (push_mask_r[sel]) begin
      push_grant = LEN_W'(free_sel);
    end else begin
      push_grant = '0;
    end
    if (32'(cnt_sel) >= 32'(len_r)) begin
      read_grant = len_r;
    end else if (cmd_r == CMD_PEEK || pop_mask_r[sel]) begin
      read_grant = LEN_W'(cnt_sel);
    end else begin
      read_grant = '0;
    end
  end

  assign rem_eff   = push_open_r ? push_rem_r : push_grant;
  assign short_eff = push_open_r ? push_short_r : (push_grant != len_r);
  assign cnt_after = (rem_eff != '0) ? cnt_sel + 1'b1 : cnt_sel;

  assign sts_o.out_free   = !out_valid_r || out_tready;
  assign sts_o.start_read = (cmd_r == CMD_PEEK || cmd_r == CMD_POP) && !bad &&
                            read_grant != '0;
  assign sts_o.read_last  = rd_left_r == LEN_W'(1);

  always_comb begin
    wr_idx_nxt     = wr_idx_r;
    rd_idx_nxt     = rd_idx_r;
    cnt_nxt        = cnt_r;
    push_rem_nxt   = push_rem_r;
    push_short_nxt = push_short_r;
    push_open_nxt  = push_open_r;
    run_ch_nxt     = run_ch_r;
    push_mask_nxt  = push_mask_r;
    pop_mask_nxt   = pop_mask_r;
    rd_left_nxt    = rd_left_r;
    rd_ptr_nxt     = rd_ptr_r;
    out_load       = 1'b0;
    out_status_nxt = STS_PARAM;
    out_data_nxt   = '0;
    out_fill_nxt   = '0;
    out_last_nxt   = 1'b1;
    ram_we         = 1'b0;
    ram_waddr      = slot_addr(sel, wr_idx_r[sel]);
    ram_re         = 1'b0;
    ram_raddr      = slot_addr(sel, rd_ptr_r);

    if (cfg_we) begin
      unique case (cfg_index)
        REG_PUSH_PARTIAL: push_mask_nxt = cfg_wdata;
        REG_POP_PARTIAL:  pop_mask_nxt  = cfg_wdata;
      endcase
    end

    if (cmd_i.exec) begin
      if (cmd_r != CMD_PUSH) begin
        push_open_nxt  = 1'b0;
        push_rem_nxt   = '0;
        push_short_nxt = 1'b0;
      end
      unique case (cmd_r)
        CMD_PUSH: begin
          out_load = 1'b1;
          if (!push_open_r && bad) begin
            out_status_nxt = STS_PARAM;
          end else begin
            run_ch_nxt = sel_ch;
            if (rem_eff != '0) begin
              ram_we          = 1'b1;
              wr_idx_nxt[sel] = next_idx(wr_idx_r[sel]);
              cnt_nxt[sel]    = cnt_after;
              push_rem_nxt    = rem_eff - 1'b1;
            end else begin
              push_rem_nxt = '0;
            end
            push_short_nxt = short_eff;
            push_open_nxt  = 1'b1;
            if (end_r) begin
              push_open_nxt  = 1'b0;
              push_rem_nxt   = '0;
              push_short_nxt = 1'b0;
            end
            out_status_nxt = short_eff ? STS_FULL : STS_OK;
            out_fill_nxt   = FILL_W'(32'(cnt_after));
          end
        end
        CMD_PEEK, CMD_POP: begin
          if (bad) begin
            out_load       = 1'b1;
            out_status_nxt = STS_PARAM;
          end else if (read_grant == '0) begin
            out_load       = 1'b1;
            out_status_nxt = STS_EMPTY;
            out_fill_nxt   = FILL_W'(32'(cnt_sel));
          end else begin
            rd_left_nxt = read_grant;
            rd_ptr_nxt  = rd_idx_r[sel];
          end
        end
        CMD_COUNT, CMD_CLEAR: begin
          out_load = 1'b1;
          if (ch_bad) begin
            out_status_nxt = STS_PARAM;
          end else begin
            out_status_nxt = STS_OK;
            if (cmd_r == CMD_CLEAR) begin
              wr_idx_nxt[sel] = '0;
              rd_idx_nxt[sel] = '0;
              cnt_nxt[sel]    = '0;
            end else begin
              out_fill_nxt = FILL_W'(32'(cnt_sel));
            end
          end
        end
        default: begin
          out_load       = 1'b1;
          out_status_nxt = STS_PARAM;
        end
      endcase
    end

    if (cmd_i.rd_issue) begin
      ram_re     = 1'b1;
      rd_ptr_nxt = next_idx(rd_ptr_r);
    end

    if (cmd_i.rd_load) begin
      out_load       = 1'b1;
      out_status_nxt = STS_OK;
      out_data_nxt   = BYTE_W'(ram_rdata);
      out_last_nxt   = rd_left_r == LEN_W'(1);
      rd_left_nxt    = rd_left_r - 1'b1;
      if (cmd_r == CMD_POP) begin
        cnt_nxt[sel]    = cnt_sel - 1'b1;
        rd_idx_nxt[sel] = next_idx(rd_idx_r[sel]);
        out_fill_nxt    = FILL_W'(32'(cnt_sel - 1'b1));
      end else begin
        out_fill_nxt = FILL_W'(32'(cnt_sel));
      end
    end

    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_idx_r     <= '{default: '0};
      rd_idx_r     <= '{default: '0};
      cnt_r        <= '{default: '0};
      push_rem_r   <= '0;
      push_short_r <= 1'b0;
      push_open_r  <= 1'b0;
      run_ch_r     <= '0;
      push_mask_r  <= '1;
      pop_mask_r   <= '1;
      rd_left_r    <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      wr_idx_r     <= wr_idx_nxt;
      rd_idx_r     <= rd_idx_nxt;
      cnt_r        <= cnt_nxt;
      push_rem_r   <= push_rem_nxt;
      push_short_r <= push_short_nxt;
      push_open_r  <= push_open_nxt;
      run_ch_r     <= run_ch_nxt;
      push_mask_r  <= push_mask_nxt;
      pop_mask_r   <= pop_mask_nxt;
      rd_left_r    <= rd_left_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    rd_ptr_r <= rd_ptr_nxt;
    if (cmd_i.load_item) begin
      cmd_r  <= cmd_t'(in_command);
      ch_r   <= in_channel;
      len_r  <= in_length;
      byte_r <= in_push_byte;
      end_r  <= in_run_end;
    end
    if (out_load) begin
      out_status_r <= out_status_nxt;
      out_data_r   <= out_data_nxt;
      out_fill_r   <= out_fill_nxt;
      out_last_r   <= out_last_nxt;
    end
  end

  mcrf_ram #(
    .WIDTH (ELEM_W),
    .DEPTH (CHANNELS * DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ELEM_W'(byte_r)),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_data   = out_data_r;
  assign out_fill   = out_fill_r;
  assign out_last   = out_last_r;

  `MCRF_ASSERT_ALWAYS(a_closed_run_idle, clk, rst_n,
                      push_open_r || (push_rem_r == '0 && !push_short_r))
  `MCRF_ASSERT_ALWAYS(a_fill_bound, clk, rst_n,
                      32'(cnt_r[0]) <= DEPTH && 32'(cnt_r[CHANNELS-1]) <= DEPTH)
  `MCRF_ASSERT_IMPLY(a_load_in_run, clk, rst_n, cmd_i.rd_load, rd_left_r != '0)
  `MCRF_ASSERT_NEXT(a_run_starts, clk, rst_n, cmd_i.exec && sts_o.start_read,
                    rd_left_r != '0 && !out_valid_r)

endmodule

// ===== bench/tb_multi_channel_ring_fifo_unit.sv =====
`timescale 1ns / 100ps
// testbench of the multi-channel ring fifo unit: directed and random command streams
// with every result word checked against a behavioural copy of both fifos
// depends on mcrf_pkg and multi_channel_ring_fifo_unit
module tb_multi_channel_ring_fifo_unit;
  import mcrf_pkg::*;

  localparam int FIFO_DEPTH  = DEFAULT_DEPTH;
  localparam int WRAP        = 2 * FIFO_DEPTH;
  localparam int CYCLE_LIMIT = 2000000;
  localparam int HOLD_CYCLES = 400;

  typedef struct {
    logic [CMD_W-1:0]   cmd;
    logic [CHSEL_W-1:0] ch;
    logic [LEN_W-1:0]   len;
    logic [BYTE_W-1:0]  data;
    logic               run_end;
  } cmd_word_t;

  typedef struct {
    status_t           st;
    logic [ELEM_W-1:0] data;
    logic [FILL_W-1:0] fill;
    logic              last;
  } response_t;

  logic                  clk;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [15:0]           in_tdata   = '0;   // length, push_byte
  logic [4:0]            in_tuser   = '0;   // command, channel
  logic                  in_tlast   = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [23:0]           out_tdata;         // data_out, fill_count
  logic [1:0]            out_tuser;         // status
  logic                  out_tlast;
  logic                  cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index  = REG_PUSH_PARTIAL;
  logic [CFG_DATA_W-1:0] cfg_wdata  = '0;

  // behavioural copy of the fifos
  logic [ELEM_W-1:0]   fifo_mem [CHANNELS][FIFO_DEPTH];
  int unsigned         wr_idx [CHANNELS];
  int unsigned         rd_idx [CHANNELS];
  int unsigned         run_left;
  int unsigned         run_ch;
  bit                  run_short;
  bit                  run_open;
  logic [CHANNELS-1:0] push_mask = '1;
  logic [CHANNELS-1:0] pop_mask  = '1;

  cmd_word_t   command_words [$];
  response_t   awaited [$];
  cmd_word_t   cur_word;
  int          words_left;
  int unsigned send_gap;
  int unsigned ready_hold;
  int unsigned cycle_count;
  int          errors;
  bit          calm;
  bit          hold_request;
  bit          hold_served;

  multi_channel_ring_fifo_unit #(.DEPTH(FIFO_DEPTH)) u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic int unsigned fill_of(int unsigned c);
    return (wr_idx[c] >= rd_idx[c]) ? wr_idx[c] - rd_idx[c] : wr_idx[c] + WRAP - rd_idx[c];
  endfunction

  function automatic int unsigned slot_of(int unsigned i);
    return (i >= FIFO_DEPTH) ? i - FIFO_DEPTH : i;
  endfunction

  function automatic int unsigned step_idx(int unsigned i);
    return (i + 1 >= WRAP) ? 0 : i + 1;
  endfunction

  function automatic void expect_response(status_t st, logic [ELEM_W-1:0] d,
                                          int unsigned fill, bit last);
    response_t r;
    r.st   = st;
    r.data = d;
    r.fill = FILL_W'(fill);
    r.last = last;
    awaited.push_back(r);
  endfunction

  function automatic void close_run();
    run_open  = 1'b0;
    run_left  = 0;
    run_short = 1'b0;
  endfunction

  // works out the result words of one accepted command word
  function automatic void run_fifo_command(cmd_word_t w);
    int unsigned c, used, grant, r, i;
    bit bad;
    bad = (w.ch >= CHANNELS) || (w.len == 0) || (w.len > MAX_RUN);
    c = w.ch;
    if (w.cmd != CMD_PUSH) close_run();
    case (w.cmd)
      CMD_PUSH: begin
        if (!run_open) begin
          if (bad) begin
            expect_response(STS_PARAM, '0, 0, 1'b1);
            return;
          end
          used = fill_of(c);
          grant = (used >= FIFO_DEPTH) ? 0 : FIFO_DEPTH - used;
          if (grant >= w.len) grant = w.len;
          else if (!push_mask[c]) grant = 0;
          run_ch    = c;
          run_left  = grant;
          run_short = (grant != w.len);
          run_open  = 1'b1;
        end
        c = run_ch;
        if (run_left > 0) begin
          fifo_mem[c][slot_of(wr_idx[c])] = w.data;
          wr_idx[c] = step_idx(wr_idx[c]);
          run_left--;
        end
        expect_response(run_short ? STS_FULL : STS_OK, '0, fill_of(c), 1'b1);
        if (w.run_end) close_run();
      end
      CMD_PEEK, CMD_POP: begin
        if (bad) begin
          expect_response(STS_PARAM, '0, 0, 1'b1);
          return;
        end
        used = fill_of(c);
        if (used >= w.len) grant = w.len;
        else if (w.cmd == CMD_PEEK || pop_mask[c]) grant = used;
        else grant = 0;
        if (grant == 0) expect_response(STS_EMPTY, '0, used, 1'b1);
        r = rd_idx[c];
        for (i = 0; i < grant; i++) begin
          if (w.cmd == CMD_POP) begin
            rd_idx[c] = step_idx(r);
            used--;
          end
          expect_response(STS_OK, fifo_mem[c][slot_of(r)], used, i + 1 == grant);
          r = step_idx(r);
        end
      end
      CMD_COUNT, CMD_CLEAR: begin
        if (w.ch >= CHANNELS) begin
          expect_response(STS_PARAM, '0, 0, 1'b1);
        end else begin
          if (w.cmd == CMD_CLEAR) begin
            wr_idx[c] = 0;
            rd_idx[c] = 0;
          end
          expect_response(STS_OK, '0, fill_of(c), 1'b1);
        end
      end
      default: expect_response(STS_PARAM, '0, 0, 1'b1);
    endcase
  endfunction

  // mostly back to back, now and then a short or a long gap
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic void queue_word(int unsigned cmd, int unsigned ch, int unsigned len,
                                     int unsigned data, bit run_end);
    cmd_word_t w;
    w.cmd     = CMD_W'(cmd);
    w.ch      = CHSEL_W'(ch);
    w.len     = LEN_W'(len);
    w.data    = BYTE_W'(data);
    w.run_end = run_end;
    command_words.push_back(w);
    words_left++;
  endfunction

  // later bytes of a run carry random channel and length, which must be ignored
  function automatic void queue_run(int unsigned ch, int unsigned len, int unsigned nbytes,
                                    bit with_end);
    int unsigned i;
    for (i = 0; i < nbytes; i++) begin
      if (i == 0)
        queue_word(CMD_PUSH, ch, len, $urandom_range(0, 255), with_end && nbytes == 1);
      else
        queue_word(CMD_PUSH, $urandom_range(0, 3), $urandom_range(0, 127),
                   $urandom_range(0, 255), with_end && i + 1 == nbytes);
    end
  endfunction

  function automatic void queue_random(int budget);
    int unsigned r, len, k;
    while (budget > 0) begin
      r = $urandom_range(0, 99);
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, MAX_RUN) : $urandom_range(1, 16);
      if (r < 45) begin
        k = $urandom_range(0, 9);
        if (k == 0) begin
          k = $urandom_range(1, len);
          queue_run($urandom_range(0, 1), len, k, 1'b0);
        end else if (k == 1) begin
          k = len + $urandom_range(1, 3);
          queue_run($urandom_range(0, 1), len, k, 1'b1);
        end else begin
          k = len;
          queue_run($urandom_range(0, 1), len, k, 1'b1);
        end
        budget -= k;
      end else begin
        if (r < 62)
          queue_word(CMD_POP, $urandom_range(0, 1), len, $urandom_range(0, 255), 1'b0);
        else if (r < 75)
          queue_word(CMD_PEEK, $urandom_range(0, 1), len, $urandom_range(0, 255), 1'b0);
        else if (r < 83)
          queue_word(CMD_COUNT, $urandom_range(0, 1), $urandom_range(0, 127), 0, 1'b0);
        else if (r < 87)
          queue_word(CMD_CLEAR, $urandom_range(0, 1), $urandom_range(0, 127), 0, 1'b0);
        else
          queue_word($urandom_range(0, 7), $urandom_range(0, 3), $urandom_range(0, 127),
                     $urandom_range(0, 255), 1'($urandom_range(0, 1)));
        budget--;
      end
    end
  endfunction

  task automatic write_masks(logic [CHANNELS-1:0] push_v, logic [CHANNELS-1:0] pop_v);
    cfg_we    <= 1'b1;
    cfg_index <= REG_PUSH_PARTIAL;
    cfg_wdata <= push_v;
    push_mask = push_v;
    @(posedge clk);
    cfg_index <= REG_POP_PARTIAL;
    cfg_wdata <= pop_v;
    pop_mask = pop_v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_drained();
    while (words_left != 0 || awaited.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // input side
  always @(posedge clk) begin
    bit busy;
    if (rst_n) begin
      busy = in_tvalid;
      if (in_tvalid && in_tready) begin
        run_fifo_command(cur_word);
        words_left--;
        busy = 1'b0;
      end
      if (!busy) begin
        if (send_gap > 0) begin
          send_gap--;
          in_tvalid <= 1'b0;
        end else if (command_words.size() > 0) begin
          cur_word = command_words.pop_front();
          in_tuser  <= {cur_word.ch, cur_word.cmd};
          in_tdata  <= {1'b0, cur_word.data, cur_word.len};
          in_tlast  <= cur_word.run_end;
          in_tvalid <= 1'b1;
          send_gap = pick_gap();
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // result side
  always @(posedge clk) begin
    response_t exp_r;
    if (rst_n && out_tvalid && out_tready) begin
      if (awaited.size() == 0) begin
        $display("%0t: unexpected word, expected none, got status %0d data %0h fill %0d last %0b",
                 $time, out_tuser, out_tdata[7:0], out_tdata[18:8], out_tlast);
        errors++;
      end else begin
        exp_r = awaited.pop_front();
        if (out_tuser !== exp_r.st) begin
          $display("%0t: status expected %0d got %0d", $time, exp_r.st, out_tuser);
          errors++;
        end
        if (out_tdata[7:0] !== exp_r.data) begin
          $display("%0t: data expected %0h got %0h", $time, exp_r.data, out_tdata[7:0]);
          errors++;
        end
        if (out_tdata[18:8] !== exp_r.fill) begin
          $display("%0t: fill expected %0d got %0d", $time, exp_r.fill, out_tdata[18:8]);
          errors++;
        end
        if (out_tlast !== exp_r.last) begin
          $display("%0t: last expected %0b got %0b", $time, exp_r.last, out_tlast);
          errors++;
        end
      end
    end
    if (ready_hold > 0) begin
      ready_hold--;
      out_tready <= 1'b0;
    end else if (hold_request && !hold_served) begin
      hold_served = 1'b1;
      ready_hold = HOLD_CYCLES - 1;
      out_tready <= 1'b0;
    end else begin
      ready_hold = pick_gap();
      out_tready <= (ready_hold == 0);
      if (ready_hold > 0) ready_hold--;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timed out", $time);
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed words, both channels partial
    write_masks(2'b11, 2'b11);
    queue_word(CMD_COUNT, 0, 0, 0, 1'b0);
    queue_word(CMD_PEEK, 0, 1, 0, 1'b0);
    queue_word(CMD_POP, 1, MAX_RUN, 0, 1'b0);
    queue_word(CMD_PUSH, 0, 3, 8'h00, 1'b0);
    queue_word(CMD_PUSH, 0, 3, 8'hff, 1'b0);
    queue_word(CMD_PUSH, 0, 3, 8'h5a, 1'b1);
    queue_word(CMD_PEEK, 0, MAX_RUN, 0, 1'b0);
    queue_word(CMD_POP, 0, 1, 0, 1'b0);
    queue_word(CMD_PUSH, 2, 1, 8'h11, 1'b1);
    queue_word(CMD_PUSH, 0, 0, 8'h22, 1'b1);
    queue_word(CMD_PUSH, 3, 127, 8'h33, 1'b1);
    queue_word(CMD_PEEK, 0, MAX_RUN + 1, 0, 1'b0);
    queue_word(CMD_POP, 3, 1, 0, 1'b0);
    queue_word(5, 0, 1, 0, 1'b0);
    queue_word(7, 1, 1, 8'hff, 1'b1);
    queue_word(CMD_COUNT, 2, 1, 0, 1'b0);
    // run left open, then closed by a count
    queue_word(CMD_PUSH, 1, 4, 8'ha1, 1'b0);
    queue_word(CMD_PUSH, 3, 0, 8'ha2, 1'b0);
    queue_word(CMD_COUNT, 1, 0, 0, 1'b0);
    // more bytes than requested, the excess is dropped
    queue_word(CMD_PUSH, 1, 2, 8'hb1, 1'b0);
    queue_word(CMD_PUSH, 0, 9, 8'hb2, 1'b0);
    queue_word(CMD_PUSH, 2, 0, 8'hb3, 1'b0);
    queue_word(CMD_PUSH, 1, 64, 8'hb4, 1'b1);
    queue_word(CMD_CLEAR, 0, 0, 0, 1'b0);
    queue_word(CMD_CLEAR, 1, 127, 0, 1'b0);
    wait_drained();

    // no partial mode: short pops give nothing, peek returns what is stored
    write_masks(2'b00, 2'b00);
    calm = 1'b1;
    queue_run(1, 20, 20, 1'b1);
    queue_word(CMD_POP, 1, 30, 0, 1'b0);
    queue_word(CMD_PEEK, 1, 30, 0, 1'b0);
    queue_word(CMD_POP, 1, 12, 0, 1'b0);
    queue_run(0, 5, 5, 1'b1);
    queue_word(CMD_POP, 0, 10, 0, 1'b0);
    queue_word(CMD_PEEK, 0, 10, 0, 1'b0);
    wait_drained();

    // partial push on channel 1 only, partial pop on channel 0 only
    write_masks(2'b10, 2'b01);
    calm = 1'b0;
    queue_random(20);
    wait_drained();

    // back to full partial mode, with a long stall on the result side
    write_masks(2'b11, 2'b11);
    hold_request = 1'b1;
    queue_random(20);
    wait_drained();

    calm = 1'b1;
    repeat (20) @(posedge clk);
    if (errors == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
